/* design/romc_pkg.sv */
// Shared codes, constants and types of the ROM-control address register unit.
package romc_pkg;

  localparam int unsigned OpWidth   = 5;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned AddrWidth = 16;
  localparam int unsigned KindWidth = 3;

  // ROM-control codes.
  localparam logic [OpWidth-1:0] OP_FETCH       = 5'h00;
  localparam logic [OpWidth-1:0] OP_BRANCH_REL  = 5'h01;
  localparam logic [OpWidth-1:0] OP_READ_DC     = 5'h02;
  localparam logic [OpWidth-1:0] OP_READ_PORT   = 5'h03;
  localparam logic [OpWidth-1:0] OP_RETURN      = 5'h04;
  localparam logic [OpWidth-1:0] OP_WRITE_DC    = 5'h05;
  localparam logic [OpWidth-1:0] OP_DRV_DC_HI   = 5'h06;
  localparam logic [OpWidth-1:0] OP_DRV_SP_HI   = 5'h07;
  localparam logic [OpWidth-1:0] OP_PUSH_DUP    = 5'h08;
  localparam logic [OpWidth-1:0] OP_DRV_DC_LO   = 5'h09;
  localparam logic [OpWidth-1:0] OP_DC_REL      = 5'h0A;
  localparam logic [OpWidth-1:0] OP_DRV_SP_LO   = 5'h0B;
  localparam logic [OpWidth-1:0] OP_READ_PC_LO  = 5'h0C;
  localparam logic [OpWidth-1:0] OP_SAVE_NEXT   = 5'h0D;
  localparam logic [OpWidth-1:0] OP_READ_DC_LO  = 5'h0E;
  localparam logic [OpWidth-1:0] OP_INTA_LO     = 5'h0F;
  localparam logic [OpWidth-1:0] OP_UNUSED      = 5'h10;
  localparam logic [OpWidth-1:0] OP_READ_DC_HI  = 5'h11;
  localparam logic [OpWidth-1:0] OP_PUSH_LO     = 5'h12;
  localparam logic [OpWidth-1:0] OP_INTA_HI     = 5'h13;
  localparam logic [OpWidth-1:0] OP_LD_PC_HI    = 5'h14;
  localparam logic [OpWidth-1:0] OP_LD_SP_HI    = 5'h15;
  localparam logic [OpWidth-1:0] OP_LD_DC_HI    = 5'h16;
  localparam logic [OpWidth-1:0] OP_LD_PC_LO    = 5'h17;
  localparam logic [OpWidth-1:0] OP_LD_SP_LO    = 5'h18;
  localparam logic [OpWidth-1:0] OP_LD_DC_LO    = 5'h19;
  localparam logic [OpWidth-1:0] OP_IO_WRITE    = 5'h1A;
  localparam logic [OpWidth-1:0] OP_IO_READ     = 5'h1B;
  localparam logic [OpWidth-1:0] OP_LD_PORT     = 5'h1C;
  localparam logic [OpWidth-1:0] OP_SWAP_DC     = 5'h1D;
  localparam logic [OpWidth-1:0] OP_DRV_PC_LO   = 5'h1E;
  localparam logic [OpWidth-1:0] OP_DRV_PC_HI   = 5'h1F;

  // Access kinds reported with each result.
  localparam logic [KindWidth-1:0] KIND_NONE    = 3'd0;
  localparam logic [KindWidth-1:0] KIND_FETCH   = 3'd1;
  localparam logic [KindWidth-1:0] KIND_MREAD   = 3'd2;
  localparam logic [KindWidth-1:0] KIND_MWRITE  = 3'd3;
  localparam logic [KindWidth-1:0] KIND_IOREAD  = 3'd4;
  localparam logic [KindWidth-1:0] KIND_IOWRITE = 3'd5;

  // Ports below this number are reserved and never accessed.
  localparam logic [ByteWidth-1:0] PORT_FLOOR = 8'd4;

  typedef struct packed {
    logic [OpWidth-1:0]   operation;
    logic [ByteWidth-1:0] data_in;
  } romc_item_t;

  typedef struct packed {
    logic [AddrWidth-1:0] address;
    logic [KindWidth-1:0] access_kind;
    logic [ByteWidth-1:0] data_out;
    logic                 data_drive;
    logic                 handled;
  } romc_result_t;

endpackage

/* design/romc_if.sv */
// Handshake channels for bus cycle items and their results.
interface romc_cmd_if;
  logic       valid;
  logic       ready;
  logic [4:0] operation;
  logic [7:0] data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink (input valid, input operation, input data_in, output ready);
endinterface

interface romc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] address;
  logic [2:0]  access_kind;
  logic [7:0]  data_out;
  logic        data_drive;
  logic        handled;

  modport source (output valid, output address, output access_kind, output data_out,
                  output data_drive, output handled, input ready);
  modport sink (input valid, input address, input access_kind, input data_out,
                input data_drive, input handled, output ready);
endinterface

/* design/romc_in_stage.sv */
// Input register that holds one bus cycle item until the execute stage takes it.
module romc_in_stage (
  input  logic               clk,
  input  logic               rst,
  romc_cmd_if.sink           cmd,
  input  logic               advance,
  output logic               valid,
  output romc_pkg::romc_item_t item
);
  import romc_pkg::*;

  assign cmd.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ready) begin
      valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.operation <= cmd.operation;
      item.data_in   <= cmd.data_in;
    end
  end

endmodule

/* design/romc_exec.sv */
// Address registers and the per-code decode that yields one result for each item.
module romc_exec (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  romc_pkg::romc_item_t         item,
  input  logic [romc_pkg::AddrWidth-1:0] interrupt_vector,
  output romc_pkg::romc_result_t       result
);
  import romc_pkg::*;

  logic [AddrWidth-1:0] program_counter, program_counter_next;
  logic [AddrWidth-1:0] stack_pointer, stack_pointer_next;
  logic [AddrWidth-1:0] data_counter, data_counter_next;
  logic [AddrWidth-1:0] alternate_data_counter, alternate_data_counter_next;
  logic [ByteWidth-1:0] io_port_latch, io_port_latch_next;

  logic [ByteWidth-1:0] d;
  logic [AddrWidth-1:0] d_sext;
  logic [AddrWidth-1:0] pc_inc;
  logic [AddrWidth-1:0] dc_inc;
  logic                 port_ok;

  assign d       = item.data_in;
  assign d_sext  = {{(AddrWidth-ByteWidth){d[ByteWidth-1]}}, d};
  assign pc_inc  = program_counter + AddrWidth'(1);
  assign dc_inc  = data_counter + AddrWidth'(1);
  assign port_ok = io_port_latch >= PORT_FLOOR;

  always_comb begin
    program_counter_next        = program_counter;
    stack_pointer_next          = stack_pointer;
    data_counter_next           = data_counter;
    alternate_data_counter_next = alternate_data_counter;
    io_port_latch_next          = io_port_latch;
    result.address     = '0;
    result.access_kind = KIND_NONE;
    result.data_out    = '0;
    result.data_drive  = 1'b0;
    result.handled     = 1'b1;

    unique case (item.operation)
      OP_FETCH: begin
        result.address       = program_counter;
        result.access_kind   = KIND_FETCH;
        program_counter_next = pc_inc;
      end
      OP_BRANCH_REL: begin
        result.address       = program_counter;
        result.access_kind   = KIND_MREAD;
        program_counter_next = program_counter + d_sext;
      end
      OP_READ_DC: begin
        result.address     = data_counter;
        result.access_kind = KIND_MREAD;
        data_counter_next  = dc_inc;
      end
      OP_READ_PORT: begin
        result.address       = program_counter;
        result.access_kind   = KIND_MREAD;
        program_counter_next = pc_inc;
        io_port_latch_next   = d;
      end
      OP_RETURN: begin
        program_counter_next = stack_pointer;
        result.handled       = 1'b0;
      end
      OP_WRITE_DC: begin
        result.address     = data_counter;
        result.access_kind = KIND_MWRITE;
        data_counter_next  = dc_inc;
      end
      OP_DRV_DC_HI: begin
        result.data_out   = data_counter[15:8];
        result.data_drive = 1'b1;
      end
      OP_DRV_SP_HI: begin
        result.data_out   = stack_pointer[15:8];
        result.data_drive = 1'b1;
      end
      OP_PUSH_DUP: begin
        stack_pointer_next   = program_counter;
        program_counter_next = {d, d};
      end
      OP_DRV_DC_LO: begin
        result.data_out   = data_counter[7:0];
        result.data_drive = 1'b1;
      end
      OP_DC_REL: begin
        data_counter_next = data_counter + d_sext;
      end
      OP_DRV_SP_LO: begin
        result.data_out   = stack_pointer[7:0];
        result.data_drive = 1'b1;
      end
      OP_READ_PC_LO: begin
        result.address       = program_counter;
        result.access_kind   = KIND_MREAD;
        program_counter_next = {program_counter[15:8], d};
      end
      OP_SAVE_NEXT: begin
        stack_pointer_next = pc_inc;
        result.handled     = 1'b0;
      end
      OP_READ_DC_LO: begin
        result.address     = program_counter;
        result.access_kind = KIND_MREAD;
        data_counter_next  = {data_counter[15:8], d};
      end
      OP_INTA_LO: begin
        result.data_out      = interrupt_vector[7:0];
        result.data_drive    = 1'b1;
        stack_pointer_next   = program_counter;
        program_counter_next = {program_counter[15:8], interrupt_vector[7:0]};
      end
      OP_UNUSED: begin
        result.handled = 1'b0;
      end
      OP_READ_DC_HI: begin
        result.address     = program_counter;
        result.access_kind = KIND_MREAD;
        data_counter_next  = {d, data_counter[7:0]};
      end
      OP_PUSH_LO: begin
        stack_pointer_next   = program_counter;
        program_counter_next = {program_counter[15:8], d};
      end
      OP_INTA_HI: begin
        result.data_out      = interrupt_vector[15:8];
        result.data_drive    = 1'b1;
        program_counter_next = {interrupt_vector[15:8], program_counter[7:0]};
      end
      OP_LD_PC_HI: program_counter_next = {d, program_counter[7:0]};
      OP_LD_SP_HI: stack_pointer_next   = {d, stack_pointer[7:0]};
      OP_LD_DC_HI: data_counter_next    = {d, data_counter[7:0]};
      OP_LD_PC_LO: program_counter_next = {program_counter[15:8], d};
      OP_LD_SP_LO: stack_pointer_next   = {stack_pointer[15:8], d};
      OP_LD_DC_LO: data_counter_next    = {data_counter[15:8], d};
      OP_IO_WRITE, OP_IO_READ: begin
        // A reserved port gives an empty cycle with nothing accessed.
        if (port_ok) begin
          result.address     = {{(AddrWidth-ByteWidth){1'b0}}, io_port_latch};
          result.access_kind = (item.operation == OP_IO_WRITE) ? KIND_IOWRITE : KIND_IOREAD;
        end else begin
          result.handled = 1'b0;
        end
      end
      OP_LD_PORT: io_port_latch_next = d;
      OP_SWAP_DC: begin
        data_counter_next           = alternate_data_counter;
        alternate_data_counter_next = data_counter;
        result.handled              = 1'b0;
      end
      OP_DRV_PC_LO: begin
        result.data_out   = program_counter[7:0];
        result.data_drive = 1'b1;
      end
      OP_DRV_PC_HI: begin
        result.data_out   = program_counter[15:8];
        result.data_drive = 1'b1;
      end
      default: result.handled = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_counter        <= '0;
      stack_pointer          <= '0;
      data_counter           <= '0;
      alternate_data_counter <= '0;
      io_port_latch          <= '0;
    end else if (advance) begin
      program_counter        <= program_counter_next;
      stack_pointer          <= stack_pointer_next;
      data_counter           <= data_counter_next;
      alternate_data_counter <= alternate_data_counter_next;
      io_port_latch          <= io_port_latch_next;
    end
  end

endmodule

/* design/romc_address_register_unit.sv */
// Top level of the ROM-control address register unit.
//
//   channel  dir  handshake       payload
//   cmd      in   valid / ready   operation[4:0], data_in[7:0]
//   rsp      out  valid / ready   address[15:0], access_kind[2:0], data_out[7:0],
//                                 data_drive, handled
//   cfg      in   cfg_wr_en       cfg_wr_data[15:0] (interrupt vector)
//
// An accepted item sits in the input register; when it advances, the code decode
// loads its result into the result register, which offers it on rsp.
// One item is accepted per cycle while rsp keeps taking results; the register
// update of each item lands as it leaves the input register.
// Reset clears all address registers, the port latch and the interrupt vector.
// A stall on rsp holds the result register and then the input register.
module romc_address_register_unit (
  input  logic                         clk,
  input  logic                         rst,
  romc_cmd_if.sink                     cmd,
  romc_rsp_if.source                   rsp,
  input  logic                         cfg_wr_en,
  input  logic [romc_pkg::AddrWidth-1:0] cfg_wr_data
);
  import romc_pkg::*;

  logic                 stage_valid;
  romc_item_t           stage_item;
  logic                 advance;
  romc_result_t         result;
  logic [AddrWidth-1:0] interrupt_vector;
  logic                 rsp_valid;
  romc_result_t         rsp_data;

  assign advance = stage_valid && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      interrupt_vector <= '0;
    end else if (cfg_wr_en) begin
      interrupt_vector <= cfg_wr_data;
    end
  end

  romc_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .advance (advance),
    .valid   (stage_valid),
    .item    (stage_item)
  );

  romc_exec u_exec (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .item             (stage_item),
    .interrupt_vector (interrupt_vector),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.address     = rsp_data.address;
  assign rsp.access_kind = rsp_data.access_kind;
  assign rsp.data_out    = rsp_data.data_out;
  assign rsp.data_drive  = rsp_data.data_drive;
  assign rsp.handled     = rsp_data.handled;

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("result register not loaded after the item advanced");

  a_full_stage_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |-> !cmd.ready)
    else $error("input taken while the input register is held");

  a_unhandled_no_access: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.handled) |-> (rsp_data.access_kind == KIND_NONE))
    else $error("unhandled code reports a bus access");

  a_idle_drive_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.data_drive) |-> (rsp_data.data_out == '0))
    else $error("data byte present without drive");

  a_no_access_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.access_kind == KIND_NONE)) |-> (rsp_data.address == '0))
    else $error("address present without an access");

endmodule
